[rtl/core/ils_pkg.sv]
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes for the indexed list store: request and result
// payloads, operation and status codes, and the per-cell command.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned DefCapacity  = 64;
  localparam int unsigned DefWordWidth = 32;

  typedef enum logic [2:0] {
    FN_APPEND = 3'd0,
    FN_INSERT = 3'd1,
    FN_REMOVE = 3'd2,
    FN_READ   = 3'd3,
    FN_CLEAR  = 3'd4
  } ils_func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } ils_status_t;

  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_REMOVE = 2'd3
  } ils_act_t;

  typedef struct packed {
    ils_func_t          func;
    logic signed [7:0]  position;
    logic [31:0]        value;
  } ils_in_t;

  typedef struct packed {
    logic [31:0]  read_value;
    ils_status_t  status;
    logic [6:0]   count;
  } ils_out_t;

endpackage

[rtl/core/ils_cell.sv]
// ----------------------------------------------------------------------------
// ils_cell
// One list entry. Takes the new word, its left or right neighbor, or holds,
// as the broadcast command and the position select.
// ----------------------------------------------------------------------------
module ils_cell
  import ils_pkg::*;
#(
  parameter int unsigned IDX        = 0,
  parameter int unsigned POS_W      = 9,
  parameter int unsigned WORD_WIDTH = DefWordWidth
) (
  input  logic                  clk,
  input  ils_act_t              act,
  input  logic [POS_W-1:0]      pos,
  input  logic [WORD_WIDTH-1:0] wr_data,
  input  logic [WORD_WIDTH-1:0] left_data,
  input  logic [WORD_WIDTH-1:0] right_data,
  output logic [WORD_WIDTH-1:0] data,
  output logic [WORD_WIDTH-1:0] rd_data
);

  localparam logic [POS_W-1:0] IdxP = POS_W'(IDX);

  logic [WORD_WIDTH-1:0] data_r;
  logic [WORD_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (act)
      ACT_HOLD: begin
        data_nxt = data_r;
      end
      ACT_APPEND: begin
        if (IdxP == pos) data_nxt = wr_data;
      end
      ACT_INSERT: begin
        if (IdxP > pos) begin
          data_nxt = left_data;
        end else if (IdxP == pos) begin
          data_nxt = wr_data;
        end
      end
      ACT_REMOVE: begin
        if (IdxP >= pos) data_nxt = right_data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (IdxP == pos) ? data_r : '0;

endmodule

[rtl/core/indexed_list_store_unit.sv]
// ----------------------------------------------------------------------------
// indexed_list_store_unit
// Bounded ordered word list with append, insert, remove, read and clear.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel and results leave on the out_ channel,
// both with valid and ready. Every request gives exactly one result that
// carries the word read or removed, a status and the entry count afterwards.
// A negative position counts back from the end of the list.
// The entries sit in a row of cells; insert and remove shift the cells from
// the position onward toward their neighbors in the same cycle, so a request
// is executed in the cycle it is accepted and its result is registered on
// the next edge. Throughput is one request per cycle while out_ready is high.
// The result register frees in the cycle it is taken, so a new request is
// accepted whenever the output is empty or being taken; a stalled receiver
// holds the result and stops requests.
// A synchronous reset empties the list and the result register. Entry contents
// are not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_list_store_unit
  import ils_pkg::*;
#(
  parameter int unsigned CAPACITY   = DefCapacity,
  parameter int unsigned WORD_WIDTH = DefWordWidth
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ils_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ils_out_t out_data
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned PosW  = ((CntW > 8) ? CntW : 8) + 1;
  localparam logic [CntW-1:0] CapC = CntW'(CAPACITY);

  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;
  logic            out_valid_r;
  ils_out_t        out_r;
  ils_out_t        out_nxt;

  logic                   fire;
  logic signed [PosW-1:0] p_ext;
  logic signed [PosW-1:0] cnt_ext;
  logic signed [PosW-1:0] res;
  logic                   in_ins_range;
  logic                   in_rd_range;
  logic                   full;
  ils_status_t            status;
  logic                   give_rd;
  ils_act_t               cmd_act;
  logic [PosW-1:0]        cmd_pos;
  logic [WORD_WIDTH-1:0]  wr_word;
  logic [WORD_WIDTH-1:0]  rd_word;

  logic [WORD_WIDTH-1:0] cell_data [CAPACITY];
  logic [WORD_WIDTH-1:0] cell_rd   [CAPACITY];

  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign fire     = in_valid && in_ready;
  assign wr_word  = WORD_WIDTH'(in_data.value);

  assign p_ext   = {{(PosW - 8){in_data.position[7]}}, in_data.position};
  assign cnt_ext = $signed({{(PosW - CntW){1'b0}}, count_r});
  assign res     = p_ext[PosW-1] ? (cnt_ext + p_ext) : p_ext;

  assign in_ins_range = !res[PosW-1] && (res <= cnt_ext);
  assign in_rd_range  = !res[PosW-1] && (res < cnt_ext);
  assign full         = (count_r == CapC);

  always_comb begin
    status    = ST_OK;
    give_rd   = 1'b0;
    cmd_act   = ACT_HOLD;
    cmd_pos   = res;
    count_nxt = count_r;
    unique case (in_data.func)
      FN_APPEND: begin
        cmd_pos = PosW'(count_r);
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd_act   = ACT_APPEND;
          count_nxt = count_r + CntW'(1);
        end
      end
      FN_INSERT: begin
        if (!in_ins_range) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          cmd_act   = ACT_INSERT;
          count_nxt = count_r + CntW'(1);
        end
      end
      FN_REMOVE: begin
        if (!in_rd_range) begin
          status = ST_RANGE;
        end else begin
          give_rd   = 1'b1;
          cmd_act   = ACT_REMOVE;
          count_nxt = count_r - CntW'(1);
        end
      end
      FN_READ: begin
        if (!in_rd_range) begin
          status = ST_RANGE;
        end else begin
          give_rd = 1'b1;
        end
      end
      FN_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
    if (!fire) begin
      cmd_act   = ACT_HOLD;
      count_nxt = count_r;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w;
    logic [WORD_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = wr_word;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    ils_cell #(
      .IDX        (i),
      .POS_W      (PosW),
      .WORD_WIDTH (WORD_WIDTH)
    ) u_cell (
      .clk        (clk),
      .act        (cmd_act),
      .pos        (cmd_pos),
      .wr_data    (wr_word),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  always_comb begin
    out_nxt.read_value = give_rd ? 32'(rd_word) : '0;
    out_nxt.status     = status;
    out_nxt.count      = 7'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CapC)
    else $error("entry count above capacity");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && (out_r.count == 7'(count_r)))
    else $error("result missing or count mismatch after request");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (status != ST_OK) |=> count_r == $past(count_r))
    else $error("rejected request changed the count");

  a_no_rd_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (status != ST_OK) |=> out_r.read_value == '0)
    else $error("nonzero read value on failed request");

endmodule
